>>> hdl/plist_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies; imported by plist_ram users and the top level.
package plist_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 5;
  localparam int CNT_OUT_W    = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_POSITION = 2'd1,
    ST_FULL         = 2'd2
  } status_t;

  typedef struct packed {
    op_t                        op;
    logic [POS_W-1:0]           position;
    logic signed [DATA_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   read_value;
    logic [CNT_OUT_W-1:0]       entry_count;
    status_t                    status;
  } rsp_t;

endpackage

>>> hdl/plist_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module plist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/positional_list_engine_unit.sv
// Positional list engine: ordered list of signed entries with insert/read/remove/clear.
// Depends on plist_pkg and plist_ram.
//
// Usage: an item is taken when start is high and busy is low. Its result appears on
// result for exactly one cycle with done high; the receiver cannot stall it. Entries sit
// in a RAM with one write and one registered read per cycle, and a single mover walks
// them one entry at a time (read, then write). Clear, a bad position, a full list and a
// remove of the last entry finish at once (busy stays low, result the next cycle). Read
// keeps busy high until the registered read data is back. Insert at p moves entries p
// to count up one slot, then writes the value; remove at p < count moves the entries
// after p down a slot. No clearing pass follows reset: only stored positions are read.
module positional_list_engine_unit #(
  parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  plist_pkg::cmd_t   cmd,
  output logic              busy,
  output logic              done,
  output plist_pkg::rsp_t   result
);

  import plist_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_READ_WAIT
  } state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic [AW-1:0]          idx;
  logic [AW-1:0]          slot;
  op_t                    op_q;
  logic [DATA_W-1:0]      val_q;

  logic                   accept;
  logic [XW-1:0]          pos_x;
  logic [XW-1:0]          cnt_x;
  logic [XW-1:0]          idx_x;
  logic                   ins_ok;
  logic                   acc_ok;
  logic                   is_full;
  logic [AW-1:0]          pos_slot;

  logic                   we;
  logic [AW-1:0]          waddr;
  logic [DATA_W-1:0]      wdata;
  logic                   re;
  logic [AW-1:0]          raddr;
  logic [DATA_W-1:0]      rdata;

  function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [CW-1:0] c);
    logic [XW-1:0] t;
    t = XW'(c);
    return t[CNT_OUT_W-1:0];
  endfunction

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign pos_x    = XW'(cmd.position);
  assign cnt_x    = XW'(count);
  assign idx_x    = XW'(idx);
  assign ins_ok   = (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
  assign acc_ok   = (pos_x != '0) && (pos_x <= cnt_x);
  assign is_full  = (cnt_x == XW'(CAPACITY));
  assign pos_slot = AW'(pos_x - XW'(1));

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rdata;
    re    = 1'b0;
    raddr = pos_slot;
    unique case (state)
      S_IDLE: begin
        re    = accept && (cmd.op == OP_READ) && acc_ok;
        raddr = pos_slot;
      end
      S_SHIFT_RD: begin
        re    = 1'b1;
        raddr = (op_q == OP_INSERT) ? AW'(idx - AW'(1)) : AW'(idx + AW'(1));
      end
      S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = idx;
        wdata = rdata;
      end
      S_INS_WR: begin
        we    = 1'b1;
        waddr = slot;
        wdata = val_q;
      end
      S_READ_WAIT: begin
        re    = 1'b0;
      end
      default: begin
        re    = 1'b0;
      end
    endcase
  end

  plist_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q  <= cmd.op;
            val_q <= cmd.value;
            slot  <= pos_slot;
            result.read_value <= '0;
            unique case (cmd.op)
              OP_INSERT: begin
                if (!ins_ok) begin
                  done               <= 1'b1;
                  result.status      <= ST_BAD_POSITION;
                  result.entry_count <= cnt_out(count);
                end else if (is_full) begin
                  done               <= 1'b1;
                  result.status      <= ST_FULL;
                  result.entry_count <= cnt_out(count);
                end else if (pos_x == cnt_x + XW'(1)) begin
                  state <= S_INS_WR;
                end else begin
                  // start moving from the tail toward the insert slot
                  idx   <= AW'(count);
                  state <= S_SHIFT_RD;
                end
              end
              OP_READ: begin
                if (!acc_ok) begin
                  done               <= 1'b1;
                  result.status      <= ST_BAD_POSITION;
                  result.entry_count <= cnt_out(count);
                end else begin
                  state <= S_READ_WAIT;
                end
              end
              OP_REMOVE: begin
                if (!acc_ok) begin
                  done               <= 1'b1;
                  result.status      <= ST_BAD_POSITION;
                  result.entry_count <= cnt_out(count);
                end else if (pos_x == cnt_x) begin
                  // last entry: nothing to close up
                  count              <= count - CW'(1);
                  done               <= 1'b1;
                  result.status      <= ST_OK;
                  result.entry_count <= cnt_out(count - CW'(1));
                end else begin
                  idx   <= pos_slot;
                  state <= S_SHIFT_RD;
                end
              end
              OP_CLEAR: begin
                count              <= '0;
                done               <= 1'b1;
                result.status      <= ST_OK;
                result.entry_count <= '0;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (op_q == OP_INSERT) begin
            if (idx_x == XW'(slot) + XW'(1)) begin
              state <= S_INS_WR;
            end else begin
              idx   <= AW'(idx - AW'(1));
              state <= S_SHIFT_RD;
            end
          end else begin
            if (idx_x + XW'(2) == cnt_x) begin
              count              <= count - CW'(1);
              done               <= 1'b1;
              result.status      <= ST_OK;
              result.entry_count <= cnt_out(count - CW'(1));
              state              <= S_IDLE;
            end else begin
              idx   <= AW'(idx + AW'(1));
              state <= S_SHIFT_RD;
            end
          end
        end
        S_INS_WR: begin
          count              <= count + CW'(1);
          done               <= 1'b1;
          result.status      <= ST_OK;
          result.entry_count <= cnt_out(count + CW'(1));
          state              <= S_IDLE;
        end
        S_READ_WAIT: begin
          done               <= 1'b1;
          result.read_value  <= rdata;
          result.status      <= ST_OK;
          result.entry_count <= cnt_out(count);
          state              <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(count) <= XW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still working");

  a_busy_starts: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> busy)
    else $error("store written while idle");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_FULL)) |-> (XW'(count) == XW'(CAPACITY)))
    else $error("full status with room left");

endmodule
